### design/wip_pkg.sv
// Shared types, constants and helpers for the weighted inner product block.
package wip_pkg;

    localparam int FREQ_FRAC_BITS = 16;
    localparam int SAMPLE_WIDTH   = 32;
    localparam int ADDR_W         = 3;
    localparam logic [ADDR_W-1:0] REG_MODE = 3'd0;

    localparam int NUM_W = 68;   // 4 * (sum of two 33x33 products)
    localparam int QUO_W = 67;   // quotient magnitude width
    localparam int TRM_W = 100;  // dx * (y0 + y1)

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROD,
        ST_DIV,
        ST_TERM,
        ST_ACC,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;      // capture input item
        logic prod;      // form numerator
        logic div_step;  // one quotient bit
        logic term_mul;  // low half of trapezoid product
        logic term_acc;  // high half, scale and accumulate
        logic finish;    // result taken / clear run state
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic term_hi_done;
        logic last;
    } sts_t;

    function automatic logic signed [63:0] sat64(input logic signed [TRM_W-1:0] v,
                                                 output logic s);
        logic signed [TRM_W-1:0] hi;
        logic signed [TRM_W-1:0] lo;
        begin
            hi = TRM_W'(64'sh7fffffffffffffff);
            lo = -TRM_W'(64'sh7fffffffffffffff) - TRM_W'(1);
            s  = 1'b0;
            if (v > hi) begin
                s = 1'b1;
                sat64 = 64'sh7fffffffffffffff;
            end else if (v < lo) begin
                s = 1'b1;
                sat64 = {1'b1, 63'd0};
            end else begin
                sat64 = v[63:0];
            end
        end
    endfunction

endpackage

### design/wip_ctrl.sv
// Sequencing state machine for the weighted inner product block.
module wip_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_fire,
    input  logic                out_fire,
    input  wip_pkg::sts_t       sts,
    output wip_pkg::cmd_t       cmd,
    output logic                s_ready,
    output logic                m_valid
);
    import wip_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_fire) state_next = ST_PROD;
            ST_PROD: state_next = ST_DIV;
            ST_DIV:  if (sts.div_done) state_next = ST_TERM;
            ST_TERM: state_next = ST_ACC;
            ST_ACC:  state_next = sts.last ? ST_OUT : ST_IDLE;
            ST_OUT:  if (out_fire) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_ready  = 1'b0;
        m_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = in_fire;
            end
            ST_PROD: cmd.prod = 1'b1;
            ST_DIV:  cmd.div_step = 1'b1;
            ST_TERM: cmd.term_mul = 1'b1;
            ST_ACC:  cmd.term_acc = 1'b1;
            ST_OUT: begin
                m_valid    = 1'b1;
                cmd.finish = out_fire;
            end
            default: ;
        endcase
    end

endmodule

### design/wip_datapath.sv
// Integrand, divider, trapezoid and accumulator datapath.
module wip_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  wip_pkg::cmd_t       cmd,
    output wip_pkg::sts_t       sts,
    input  logic                mode,
    input  logic [31:0]         freq,
    input  logic signed [31:0]  a_re,
    input  logic signed [31:0]  a_im,
    input  logic signed [31:0]  b_re,
    input  logic signed [31:0]  b_im,
    input  logic [31:0]         noise,
    input  logic                last,
    output logic signed [63:0]  total,
    output logic                overflow
);
    import wip_pkg::*;

    localparam int CNT_W = $clog2(QUO_W + 1);

    // captured item
    logic [31:0]         freq_reg;
    logic signed [32:0]  p_reg, q_reg, r_reg, s_reg;   // product operands
    logic [31:0]         nz_reg;
    logic                last_reg, mode_reg;

    // divider
    logic [NUM_W-1:0]    num_reg, num_next;
    logic                neg_reg;
    logic [QUO_W-1:0]    quo_reg;
    logic [32:0]         rem_reg;
    logic [CNT_W-1:0]    cnt_reg;

    // run state
    logic [31:0]         prev_freq_reg;
    logic signed [63:0]  prev_y_reg, y_reg;
    logic signed [63:0]  sum_reg;
    logic                have_prev_reg, sat_reg, ysat_reg;
    logic signed [33:0]  dx_reg;
    logic signed [64:0]  ys_reg;
    logic signed [TRM_W-1:0] tlo_reg;

    logic signed [SAMPLE_WIDTH-1:0] ar, ai, br, bi;
    assign ar = a_re[SAMPLE_WIDTH-1:0];
    assign ai = a_im[SAMPLE_WIDTH-1:0];
    assign br = b_re[SAMPLE_WIDTH-1:0];
    assign bi = b_im[SAMPLE_WIDTH-1:0];

    // operand pick at load time
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            freq_reg <= freq;
            nz_reg   <= (noise == 32'd0) ? 32'd1 : noise;
            last_reg <= last;
            mode_reg <= mode;
            if (mode) begin
                p_reg <= 33'(ar) - 33'(br);
                q_reg <= 33'(ar) - 33'(br);
                r_reg <= 33'(ai) - 33'(bi);
                s_reg <= 33'(ai) - 33'(bi);
            end else begin
                p_reg <= 33'(ar);
                q_reg <= 33'(br);
                r_reg <= 33'(ai);
                s_reg <= 33'(bi);
            end
        end
    end

    // numerator, sign/magnitude
    logic signed [NUM_W-1:0] num_s;
    always_comb begin
        num_s = (NUM_W'(p_reg * q_reg) + NUM_W'(r_reg * s_reg)) <<< 2;
        num_next = num_s[NUM_W-1] ? NUM_W'(-num_s) : NUM_W'(num_s);
    end

    // restoring divider, one quotient bit a cycle
    logic [33:0] trial;
    assign trial = {rem_reg, num_reg[QUO_W-1]} - {2'b00, nz_reg};

    always_ff @(posedge aclk) begin
        if (cmd.prod) begin
            num_reg <= num_next;
            neg_reg <= num_s[NUM_W-1];
            rem_reg <= '0;
            quo_reg <= '0;
            cnt_reg <= '0;
        end else if (cmd.div_step) begin
            num_reg <= num_reg << 1;
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (!trial[33]) begin
                rem_reg <= trial[32:0];
                quo_reg <= {quo_reg[QUO_W-2:0], 1'b1};
            end else begin
                rem_reg <= {rem_reg[31:0], num_reg[QUO_W-1]};
                quo_reg <= {quo_reg[QUO_W-2:0], 1'b0};
            end
        end
    end
    assign sts.div_done = (cnt_reg == CNT_W'(QUO_W - 1));
    assign sts.term_hi_done = 1'b1;
    assign sts.last = last_reg;

    // signed quotient, saturated; this is the next integrand
    logic signed [TRM_W-1:0] qs;
    logic signed [63:0]      ycur;
    logic                    ys;
    logic [QUO_W-1:0]        qfin;
    always_comb begin
        qfin = trial[33] ? {quo_reg[QUO_W-2:0], 1'b0} : {quo_reg[QUO_W-2:0], 1'b1};
        qs   = neg_reg ? -TRM_W'(qfin) : TRM_W'(qfin);
        ycur = sat64(qs, ys);
    end

    // trapezoid: two 34x~33 partial products, low half first
    logic signed [TRM_W-1:0] tfull, tsh, sumw;
    logic signed [63:0]      term, sum_new;
    logic                    tsat, ssat;
    always_comb begin
        tfull   = tlo_reg + (TRM_W'(dx_reg * $signed(ys_reg[64:32])) <<< 32);
        tsh     = tfull >>> (FREQ_FRAC_BITS + 1);
        term    = sat64(tsh, tsat);
        sumw    = TRM_W'(sum_reg) + TRM_W'(term);
        sum_new = sat64(sumw, ssat);
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_step && sts.div_done) begin
            y_reg    <= ycur;
            ysat_reg <= ys;
            dx_reg   <= 34'(freq_reg) - 34'(prev_freq_reg);
            ys_reg   <= 65'(prev_y_reg) + 65'(ycur);
        end
        if (cmd.term_mul) begin
            tlo_reg <= TRM_W'(dx_reg * $signed({1'b0, ys_reg[31:0]}));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_freq_reg <= '0;
            prev_y_reg    <= '0;
            sum_reg       <= '0;
            have_prev_reg <= 1'b0;
            sat_reg       <= 1'b0;
        end else if (cmd.finish) begin
            prev_freq_reg <= '0;
            prev_y_reg    <= '0;
            sum_reg       <= '0;
            have_prev_reg <= 1'b0;
            sat_reg       <= 1'b0;
        end else if (cmd.term_acc) begin
            prev_freq_reg <= freq_reg;
            prev_y_reg    <= y_reg;
            have_prev_reg <= 1'b1;
            if (have_prev_reg) begin
                sum_reg <= sum_new;
                sat_reg <= sat_reg | ysat_reg | tsat | ssat;
            end else begin
                sat_reg <= sat_reg | ysat_reg;
            end
        end
    end

    // mode 1: -(sum/2), truncation toward zero
    logic signed [63:0] half;
    assign half     = (sum_reg + 64'(sum_reg[63] ? 1 : 0)) >>> 1;
    assign total    = mode_reg ? -half : sum_reg;
    assign overflow = sat_reg;

endmodule

### design/weighted_inner_product_trapezoid.sv
// Top level: noise-weighted inner product with trapezoid integration.
//
// Usage
//   Input channel s_*: one frequency sample per transfer (freq, a, b,
//   noise, last). Result channel m_*: one transfer per run, carrying
//   m_total and m_overflow, issued after the sample with s_last set.
//   APB port: register 0 (address 0) is mode, 0 overlap, 1 log-likelihood.
//   Write mode only while the block is idle.
// Sequence
//   Each sample passes through capture, numerator, the
//   one-bit-per-cycle restoring divider for the noise division, and
//   the split trapezoid multiply and accumulate; s_ready is low until
//   that accumulate is done. A result appears in the cycle after the last
//   sample's accumulate; s_ready stays low until it is taken.
// Reset
//   aresetn (synchronous, low) clears mode, the run state and the FSM.
// Stall
//   If m_ready is low the result holds and no new sample is taken.
module weighted_inner_product_trapezoid (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [31:0]        s_freq,
    input  logic signed [31:0] s_a_re,
    input  logic signed [31:0] s_a_im,
    input  logic signed [31:0] s_b_re,
    input  logic signed [31:0] s_b_im,
    input  logic [31:0]        s_noise,
    input  logic               s_last,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [63:0] m_total,
    output logic               m_overflow
);
    import wip_pkg::*;

    logic  mode_reg;
    cmd_t  cmd;
    sts_t  sts;
    logic  in_fire, out_fire;

    assign pready = 1'b1;
    // register file: only mode
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
        end else if (psel && penable && pwrite && paddr[4:2] == REG_MODE) begin
            mode_reg <= pwdata[0];
        end
    end
    assign prdata = (paddr[4:2] == REG_MODE) ? {31'd0, mode_reg} : 32'd0;

    assign in_fire  = s_valid && s_ready;
    assign out_fire = m_valid && m_ready;

    wip_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (in_fire),
        .out_fire (out_fire),
        .sts      (sts),
        .cmd      (cmd),
        .s_ready  (s_ready),
        .m_valid  (m_valid)
    );

    wip_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .mode     (mode_reg),
        .freq     (s_freq),
        .a_re     (s_a_re),
        .a_im     (s_a_im),
        .b_re     (s_b_re),
        .b_im     (s_b_im),
        .noise    (s_noise),
        .last     (s_last),
        .total    (m_total),
        .overflow (m_overflow)
    );

endmodule
